FILE: hdl/urlpd_pkg.sv
`default_nettype none
package urlpd_pkg;

   // Most decoded bytes kept per string is MAX_LEN-1 or out_limit, whichever is less.
   localparam int MAX_LEN     = 4096;
   localparam int LIMIT_W     = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam int         HEX_RADIX    = 16;

   // An accepted input byte that yields output or ends a string turns into a group of one to three beats.
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            present;
      logic            last;
   } group_type;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
   } beat_type;

   function automatic logic is_hex(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
   endfunction

   // Digits carry their value in the low nibble; letters of both cases sit nine below it.
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) begin
         return c[3:0];
      end
      return c[3:0] + 4'd9;
   endfunction

   function automatic logic [7:0] hex_byte(input logic [7:0] hi, input logic [7:0] lo);
      logic [11:0] v;
      v = 12'(hex_val(hi)) * 12'(HEX_RADIX) + 12'(hex_val(lo));
      return v[7:0];
   endfunction

endpackage
`default_nettype wire

FILE: hdl/urlpd_front.sv
`default_nettype none
module urlpd_front
   import urlpd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_in_end,
   input  wire logic               csr_valid,
   input  wire logic [LIMIT_W-1:0] csr_out_limit,
   input  wire logic               queue_full,
   output      logic               enq,
   output      group_type          enq_group
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ONE  = 2'd1;
   localparam logic [1:0] PH_TWO  = 2'd2;
   localparam int         CAP     = MAX_LEN - 1;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         held_ff, held_in;
   logic [LIMIT_W-1:0] count_ff, count_in;

   logic               accept;
   logic [7:0]         cand [0:2];
   logic [1:0]         nc;
   logic [1:0]         phase_nx;
   logic [7:0]         held_nx;
   logic               do_plain;
   logic [LIMIT_W-1:0] bound;
   logic [LIMIT_W-1:0] room;
   logic [1:0]         keep;

   assign accept = req_push && !queue_full;

   // Classify the byte against the escape phase and list the candidate bytes in order.
   always_comb begin
      cand[0]  = '0;
      cand[1]  = '0;
      cand[2]  = '0;
      nc       = 2'd0;
      phase_nx = phase_ff;
      held_nx  = held_ff;
      do_plain = 1'b0;
      case (phase_ff)
         PH_ONE: begin
            if (is_hex(req_in_byte)) begin
               held_nx  = req_in_byte;
               phase_nx = PH_TWO;
            end else begin
               cand[0]  = CHAR_PERCENT;
               nc       = 2'd1;
               do_plain = 1'b1;
            end
         end
         PH_TWO: begin
            if (is_hex(req_in_byte)) begin
               cand[0]  = hex_byte(held_ff, req_in_byte);
               nc       = 2'd1;
               phase_nx = PH_IDLE;
            end else begin
               cand[0]  = CHAR_PERCENT;
               cand[1]  = held_ff;
               nc       = 2'd2;
               do_plain = 1'b1;
            end
         end
         default: begin
            do_plain = 1'b1;
         end
      endcase
      if (do_plain) begin
         phase_nx = PH_IDLE;
         if (req_in_byte == CHAR_PLUS) begin
            cand[nc] = CHAR_SPACE;
            nc       = nc + 2'd1;
         end else if (req_in_byte == CHAR_PERCENT) begin
            phase_nx = PH_ONE;
         end else begin
            cand[nc] = req_in_byte;
            nc       = nc + 2'd1;
         end
      end
      // Flush a pending escape literally at the end of the string.
      if (req_in_end) begin
         if (phase_nx == PH_ONE) begin
            cand[nc] = CHAR_PERCENT;
            nc       = nc + 2'd1;
         end else if (phase_nx == PH_TWO) begin
            cand[0] = CHAR_PERCENT;
            cand[1] = held_nx;
            nc      = 2'd2;
         end
      end
   end

   // Keep only as many candidates as the limit still allows.
   always_comb begin
      bound = (32'(limit_ff) < CAP) ? limit_ff : LIMIT_W'(CAP);
      room  = (count_ff < bound) ? (bound - count_ff) : '0;
      keep  = (room < LIMIT_W'(nc)) ? room[1:0] : nc;
   end

   always_comb begin
      enq                = accept && ((keep != 2'd0) || req_in_end);
      enq_group.data[0]  = (keep == 2'd0) ? 8'd0 : cand[0];
      enq_group.data[1]  = cand[1];
      enq_group.data[2]  = cand[2];
      enq_group.count    = (keep == 2'd0) ? 2'd1 : keep;
      enq_group.present  = keep != 2'd0;
      enq_group.last     = req_in_end;
   end

   always_comb begin
      limit_in = csr_valid ? csr_out_limit : limit_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_in_end) begin
            phase_in = PH_IDLE;
            held_in  = '0;
            count_in = '0;
         end else begin
            phase_in = phase_nx;
            held_in  = held_nx;
            count_in = count_ff + LIMIT_W'(keep);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '1;
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
         count_ff <= '0;
      end else begin
         limit_ff <= limit_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/urlpd_queue.sv
`default_nettype none
module urlpd_queue
   import urlpd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      enq,
   input  group_type      enq_group,
   input  wire logic      deq,
   output      logic      full,
   output      logic      empty,
   output      group_type head
);

   group_type         slot_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_enq;
   logic              do_deq;

   assign full   = fill_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty  = fill_ff == '0;
   assign head   = slot_ff[rd_ff];
   assign do_enq = enq && !full;
   assign do_deq = deq && !empty;

   always_comb begin
      wr_in   = do_enq ? wr_ff + 1'b1 : wr_ff;
      rd_in   = do_deq ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (QPTR_W+1)'(do_enq) - (QPTR_W+1)'(do_deq);
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         slot_ff[wr_ff] <= enq_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/urlpd_back.sv
`default_nettype none
module urlpd_back
   import urlpd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      queue_empty,
   input  group_type      head,
   output      logic      deq,
   input  wire logic      rsp_pop,
   output      logic      rsp_empty,
   output      beat_type  rsp_beat
);

   logic       valid_ff, valid_in;
   beat_type   beat_ff, beat_in;
   logic [1:0] idx_ff, idx_in;
   logic       advance;
   logic       tail;

   // Advance when the output register is free or its beat goes out now.
   assign advance = !valid_ff || rsp_pop;
   assign tail    = idx_ff == (head.count - 2'd1);
   assign deq     = advance && !queue_empty && tail;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      idx_in   = idx_ff;
      if (advance) begin
         valid_in = !queue_empty;
         if (!queue_empty) begin
            beat_in.data    = head.data[idx_ff];
            beat_in.present = head.present;
            beat_in.last    = head.last && tail;
            idx_in          = tail ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_beat  = beat_ff;

endmodule
`default_nettype wire

FILE: hdl/url_percent_decoder.sv
// URL percent decoder.
// Input channel (req_): push one raw byte of an encoded string per beat, with
// req_in_end on the final byte. A beat is taken when req_push is high and
// req_full is low. One byte is taken every cycle while req_full stays low.
// Result channel (rsp_): a queue read port. While rsp_empty is low the oldest
// decoded beat sits on rsp_out_byte / rsp_byte_present / rsp_out_end; pulse
// rsp_pop to take it. '+' becomes a space, "%hh" becomes one byte, a broken
// escape comes out literally. A beat with rsp_byte_present low is a bare end
// marker (byte zero); rsp_out_end flags the last beat of every string.
// A decoded byte passes through the queue and then the output register before it
// shows on the result ports. Unless the receiver stalls, the back end drains one beat
// a cycle, so an input byte that releases two or three bytes holds the output for
// that many beats; the four-group queue between front and back absorbs such
// bursts, and req_full rises only when it fills.
// csr_: write the 12-bit out_limit (bytes kept per string) while idle;
// csr_ready is always high.
// Reset (synchronous, high) empties the queue and output register, clears the
// escape and byte-count state and sets out_limit to 4095. When the receiver
// stalls, the output beat holds and the queue fills, then req_full stalls the
// sender; nothing is dropped.
`default_nettype none
module url_percent_decoder
   import urlpd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output      logic               req_full,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_in_end,
   output      logic               rsp_empty,
   input  wire logic               rsp_pop,
   output      logic [7:0]         rsp_out_byte,
   output      logic               rsp_byte_present,
   output      logic               rsp_out_end,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [LIMIT_W-1:0] csr_out_limit
);

   logic      queue_full;
   logic      queue_empty;
   logic      enq;
   logic      deq;
   group_type enq_group;
   group_type head;
   beat_type  rsp_beat;

   // Classify the byte and enqueue its group of decoded beats.
   urlpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_in_byte   (req_in_byte),
      .req_in_end    (req_in_end),
      .csr_valid     (csr_valid),
      .csr_out_limit (csr_out_limit),
      .queue_full    (queue_full),
      .enq           (enq),
      .enq_group     (enq_group)
   );

   urlpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq       (enq),
      .enq_group (enq_group),
      .deq       (deq),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   // Serialize each group into result beats behind an output register.
   urlpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .deq         (deq),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_beat    (rsp_beat)
   );

   assign req_full         = queue_full;
   assign csr_ready        = 1'b1;
   assign rsp_out_byte     = rsp_beat.data;
   assign rsp_byte_present = rsp_beat.present;
   assign rsp_out_end      = rsp_beat.last;

endmodule
`default_nettype wire

FILE: hdl/urlpd_checker.sv
`default_nettype none
module urlpd_checker
   import urlpd_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_push,
   input wire logic               req_full,
   input wire logic [7:0]         req_in_byte,
   input wire logic               req_in_end,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic [7:0]         rsp_out_byte,
   input wire logic               rsp_byte_present,
   input wire logic               rsp_out_end,
   input wire logic               csr_valid,
   input wire logic               csr_ready,
   input wire logic [LIMIT_W-1:0] csr_out_limit
);

   // Reset leaves nothing to read and room to write.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not clear after reset");

   // A bare terminator always closes a string and carries a zero byte.
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_byte_present) |-> (rsp_out_end && (rsp_out_byte == 8'd0)))
      else $error("bare terminator malformed");

   // A stalled result beat holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_byte_present)
          && $stable(rsp_out_end)))
      else $error("result beat changed while stalled");

   // The queue cannot fill while no input beat is pushed.
   a_full_rise: assert property (@(posedge clock) disable iff (reset)
      (!req_full && !(req_push && !req_in_end && (req_in_byte == 8'd0)) && !req_push)
         |=> !req_full)
      else $error("input stalled with no beat taken");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write refused");

endmodule

bind url_percent_decoder urlpd_checker u_urlpd_checker (.*);
`default_nettype wire
